/* sv/lbm_pkg.sv */
package lbm_pkg;

  localparam int MaxWidth    = 1024;
  localparam int HeightLimit = 4096;
  localparam int LabelBits   = 16;
  localparam int ColBits     = $clog2(MaxWidth);
  localparam int RowBits     = 13;
  localparam int OutRowBits  = 12;
  localparam int WidthBits   = 11;
  localparam int HeightBits  = 13;
  localparam int ChanBits    = 8;
  localparam int RegionBits  = 16;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 32;

  // front-to-back queue and result buffer depths
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);
  localparam int QCntBits  = $clog2(QDepth + 1);
  localparam int ODepth    = 4;
  localparam int OPtrBits  = $clog2(ODepth);
  localparam int OCntBits  = $clog2(ODepth + 1);

  localparam logic [ChanBits-1:0] BoundaryRed = 8'd255;

  // register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef logic [ColBits-1:0]     col_t;
  typedef logic [RowBits-1:0]     row_t;
  typedef logic [OutRowBits-1:0]  orow_t;
  typedef logic [LabelBits-1:0]   lab_t;
  typedef logic [3*ChanBits-1:0]  rgb_t;
  typedef logic [ChanBits-1:0]    chan_t;
  typedef logic [WidthBits-1:0]   wreg_t;
  typedef logic [HeightBits-1:0]  hreg_t;
  typedef logic [QPtrBits-1:0]    qptr_t;
  typedef logic [QCntBits-1:0]    qcnt_t;
  typedef logic [OPtrBits-1:0]    optr_t;
  typedef logic [OCntBits-1:0]    ocnt_t;

  // effective frame geometry after clamping
  typedef struct packed {
    col_t w_m1;
    row_t h;
  } geom_t;

  // classified pixel, handed from front to back
  typedef struct packed {
    col_t  col;
    lab_t  lab;
    rgb_t  colour;
    logic  has_res;
    logic  top;
    logic  bottom;
    logic  left;
    logic  right;
    logic  frame_end;
    orow_t er;
    col_t  ec;
  } item_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    logic  boundary;
    orow_t row;
    col_t  col;
    logic  frame_end;
  } result_t;

  typedef struct packed {
    logic  full;
    qcnt_t cnt;
  } qstat_t;

  typedef struct packed {
    ocnt_t ocnt;
    logic  r_valid;
  } bstat_t;

endpackage

/* sv/lbm_front.sv */
module lbm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  lbm_pkg::geom_t                   geom,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lbm_pkg::ChanBits-1:0]     in_blue,
  input  logic [lbm_pkg::ChanBits-1:0]     in_green,
  input  logic [lbm_pkg::ChanBits-1:0]     in_red,
  input  logic [lbm_pkg::RegionBits-1:0]   in_region_label,
  input  logic                             in_flush,
  input  lbm_pkg::qstat_t                  qstat,
  output logic                             push,
  output lbm_pkg::item_t                   push_item
);

  lbm_pkg::row_t row_r, row_nxt, row, h_p1, er, bot_row;
  lbm_pkg::col_t col_r, col_nxt, col;
  logic          flush_go, restart_row, proc, col_nz, last_col;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready && proc;

  always_comb begin
    h_p1        = geom.h + lbm_pkg::row_t'(1);
    // a flush counts only while the drain of the finished frame is open
    flush_go    = (row_r == geom.h) || ((row_r == h_p1) && (col_r == '0));
    restart_row = !in_flush && (row_r >= geom.h);
    row         = restart_row ? '0 : row_r;
    col         = restart_row ? '0 : col_r;
    proc        = !in_flush || flush_go;
    col_nz      = (col != '0);
    er          = row - (col_nz ? lbm_pkg::row_t'(1) : lbm_pkg::row_t'(2));
    bot_row     = col_nz ? row : row - lbm_pkg::row_t'(1);

    push_item.col       = col;
    push_item.lab       = in_flush ? '0 : in_region_label[lbm_pkg::LabelBits-1:0];
    push_item.colour    = in_flush ? '0 : {in_red, in_green, in_blue};
    push_item.has_res   = col_nz ? (row >= lbm_pkg::row_t'(1)) : (row >= lbm_pkg::row_t'(2));
    push_item.top       = (er != '0);
    push_item.bottom    = (bot_row < geom.h);
    push_item.left      = col_nz ? (col >= lbm_pkg::col_t'(2)) : (geom.w_m1 != '0);
    push_item.right     = col_nz;
    push_item.frame_end = !col_nz && (row == h_p1);
    push_item.er        = er[lbm_pkg::OutRowBits-1:0];
    push_item.ec        = col_nz ? col - lbm_pkg::col_t'(1) : geom.w_m1;

    last_col = (col == geom.w_m1);
    col_nxt  = last_col ? '0 : col + lbm_pkg::col_t'(1);
    row_nxt  = last_col ? row + lbm_pkg::row_t'(1) : row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (restart) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

/* sv/lbm_queue.sv */
module lbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lbm_pkg::item_t  push_item,
  input  logic            pop,
  output logic            head_valid,
  output lbm_pkg::item_t  head_item,
  output lbm_pkg::qstat_t qstat
);

  lbm_pkg::item_t q_r [lbm_pkg::QDepth];
  lbm_pkg::qptr_t wptr_r, rptr_r;
  lbm_pkg::qcnt_t cnt_r;

  assign head_valid = (cnt_r != '0);
  assign head_item  = q_r[rptr_r];
  assign qstat.full = (cnt_r == lbm_pkg::qcnt_t'(lbm_pkg::QDepth));
  assign qstat.cnt  = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + lbm_pkg::qptr_t'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + lbm_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + lbm_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - lbm_pkg::qcnt_t'(1);
      end
    end
  end

endmodule

/* sv/lbm_back.sv */
module lbm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  lbm_pkg::item_t                  head_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lbm_pkg::ChanBits-1:0]    out_blue,
  output logic [lbm_pkg::ChanBits-1:0]    out_green,
  output logic [lbm_pkg::ChanBits-1:0]    out_red,
  output logic                            out_on_boundary,
  output logic [lbm_pkg::OutRowBits-1:0]  out_row,
  output logic [lbm_pkg::ColBits-1:0]     out_col,
  output logic                            out_frame_end,
  output lbm_pkg::bstat_t                 bstat
);

  // line stores, one entry per column
  lbm_pkg::lab_t near_line_r [lbm_pkg::MaxWidth];
  lbm_pkg::lab_t far_line_r  [lbm_pkg::MaxWidth];
  lbm_pkg::rgb_t colr_line_r [lbm_pkg::MaxWidth];

  lbm_pkg::lab_t near_rd_r, far_rd_r;
  lbm_pkg::rgb_t colr_rd_r, hold_r;

  // read stage
  logic           r_valid_r;
  lbm_pkg::item_t r_r;

  lbm_pkg::lab_t  win_r [9];
  lbm_pkg::lab_t  win_n [9];
  logic [8:0]     nb_ok;
  logic           bnd_hit;
  lbm_pkg::result_t res;

  // result buffer
  lbm_pkg::result_t ofifo_r [lbm_pkg::ODepth];
  lbm_pkg::optr_t   owptr_r, orptr_r;
  lbm_pkg::ocnt_t   ocnt_r;
  logic             opush, opop;

  // only pull from the queue when the buffer has room for everything in flight
  assign pop = head_valid &&
               ((ocnt_r + lbm_pkg::ocnt_t'(r_valid_r)) < lbm_pkg::ocnt_t'(lbm_pkg::ODepth));

  always_ff @(posedge clk) begin
    if (pop) begin
      near_rd_r                  <= near_line_r[head_item.col];
      near_line_r[head_item.col] <= head_item.lab;
      colr_rd_r                  <= colr_line_r[head_item.col];
      colr_line_r[head_item.col] <= head_item.colour;
    end
  end

  // far line is written in the cycle after the read; bypass when the read hits that column
  always_ff @(posedge clk) begin
    if (pop) begin
      if (r_valid_r && (r_r.col == head_item.col)) begin
        far_rd_r <= near_rd_r;
      end else begin
        far_rd_r <= far_line_r[head_item.col];
      end
    end
    if (r_valid_r) begin
      far_line_r[r_r.col] <= near_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else begin
      r_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_r <= head_item;
    end
  end

  always_comb begin
    win_n[0] = win_r[1];
    win_n[1] = win_r[2];
    win_n[2] = far_rd_r;
    win_n[3] = win_r[4];
    win_n[4] = win_r[5];
    win_n[5] = near_rd_r;
    win_n[6] = win_r[7];
    win_n[7] = win_r[8];
    win_n[8] = r_r.lab;

    nb_ok[0] = r_r.top && r_r.left;
    nb_ok[1] = r_r.top;
    nb_ok[2] = r_r.top && r_r.right;
    nb_ok[3] = r_r.left;
    nb_ok[4] = 1'b0;
    nb_ok[5] = r_r.right;
    nb_ok[6] = r_r.bottom && r_r.left;
    nb_ok[7] = r_r.bottom;
    nb_ok[8] = r_r.bottom && r_r.right;

    bnd_hit = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (nb_ok[i] && (win_n[i] != win_n[4])) begin
        bnd_hit = 1'b1;
      end
    end

    res.blue      = bnd_hit ? '0 : hold_r[lbm_pkg::ChanBits-1:0];
    res.green     = bnd_hit ? '0 : hold_r[2*lbm_pkg::ChanBits-1:lbm_pkg::ChanBits];
    res.red       = bnd_hit ? lbm_pkg::BoundaryRed
                            : hold_r[3*lbm_pkg::ChanBits-1:2*lbm_pkg::ChanBits];
    res.boundary  = bnd_hit;
    res.row       = r_r.er;
    res.col       = r_r.ec;
    res.frame_end = r_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (r_valid_r) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_n[i];
      end
      hold_r <= colr_rd_r;
    end
  end

  assign opush = r_valid_r && r_r.has_res;
  assign opop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo_r[owptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (opush) begin
        owptr_r <= owptr_r + lbm_pkg::optr_t'(1);
      end
      if (opop) begin
        orptr_r <= orptr_r + lbm_pkg::optr_t'(1);
      end
      if (opush && !opop) begin
        ocnt_r <= ocnt_r + lbm_pkg::ocnt_t'(1);
      end else if (opop && !opush) begin
        ocnt_r <= ocnt_r - lbm_pkg::ocnt_t'(1);
      end
    end
  end

  assign out_valid       = (ocnt_r != '0);
  assign out_blue        = ofifo_r[orptr_r].blue;
  assign out_green       = ofifo_r[orptr_r].green;
  assign out_red         = ofifo_r[orptr_r].red;
  assign out_on_boundary = ofifo_r[orptr_r].boundary;
  assign out_row         = ofifo_r[orptr_r].row;
  assign out_col         = ofifo_r[orptr_r].col;
  assign out_frame_end   = ofifo_r[orptr_r].frame_end;

  assign bstat.ocnt    = ocnt_r;
  assign bstat.r_valid = r_valid_r;

endmodule

/* sv/label_boundary_marker.sv */
// channel | direction | transfer when          | payload
// in_     | sink      | in_valid & in_ready    | colour, region label, flush
// out_    | source    | out_valid & out_ready  | colour, boundary flag, row, col, frame end
// cfg_    | APB slave | psel & penable & pwrite| frame_width @0x0, frame_height @0x4
//
// One pixel per clock sustained. Each transfer moves through the front
// classifier, a 4-entry queue, a read stage over the line stores and a
// 4-entry result buffer; with empty queues, a transfer completing a pixel's
// 3x3 neighborhood is registered in queue, read stage and buffer. The line
// stores have one read and one write port each, which sets the pixel rate.
// Reset (rst_n low, synchronous) clears counters, queue and buffer; line
// stores need no clearing pass. Either side may stall: a full queue drops
// in_ready, and the back end stops pulling when the result buffer is spoken for.
module label_boundary_marker (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lbm_pkg::ChanBits-1:0]     in_blue,
  input  logic [lbm_pkg::ChanBits-1:0]     in_green,
  input  logic [lbm_pkg::ChanBits-1:0]     in_red,
  input  logic [lbm_pkg::RegionBits-1:0]   in_region_label,
  input  logic                             in_flush,
  // marked pixel output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbm_pkg::ChanBits-1:0]     out_blue,
  output logic [lbm_pkg::ChanBits-1:0]     out_green,
  output logic [lbm_pkg::ChanBits-1:0]     out_red,
  output logic                             out_on_boundary,
  output logic [lbm_pkg::OutRowBits-1:0]   out_row,
  output logic [lbm_pkg::ColBits-1:0]      out_col,
  output logic                             out_frame_end,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lbm_pkg::CfgAddrBits-1:0]  cfg_paddr,
  input  logic [lbm_pkg::CfgDataBits-1:0]  cfg_pwdata,
  output logic [lbm_pkg::CfgDataBits-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  lbm_pkg::wreg_t   width_r;
  lbm_pkg::hreg_t   height_r;
  logic             cfg_wr;
  logic             reg_sel;
  lbm_pkg::geom_t   geom;

  logic             push, pop, head_valid;
  lbm_pkg::item_t   push_item, head_item;
  lbm_pkg::qstat_t  qstat;
  lbm_pkg::bstat_t  bstat;

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the stream position.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lbm_pkg::wreg_t'(640);
      height_r <= lbm_pkg::hreg_t'(480);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lbm_pkg::RegWidth:  width_r  <= cfg_pwdata[lbm_pkg::WidthBits-1:0];
        lbm_pkg::RegHeight: height_r <= cfg_pwdata[lbm_pkg::HeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lbm_pkg::RegWidth:  cfg_prdata = lbm_pkg::CfgDataBits'(width_r);
      lbm_pkg::RegHeight: cfg_prdata = lbm_pkg::CfgDataBits'(height_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Clamp width to 1..MaxWidth and height to 1..HeightLimit.
  always_comb begin
    if (width_r == '0) begin
      geom.w_m1 = '0;
    end else if (int'(width_r) > lbm_pkg::MaxWidth) begin
      geom.w_m1 = lbm_pkg::col_t'(lbm_pkg::MaxWidth - 1);
    end else begin
      geom.w_m1 = lbm_pkg::col_t'(width_r - lbm_pkg::wreg_t'(1));
    end
    if (height_r == '0) begin
      geom.h = lbm_pkg::row_t'(1);
    end else if (int'(height_r) > lbm_pkg::HeightLimit) begin
      geom.h = lbm_pkg::row_t'(lbm_pkg::HeightLimit);
    end else begin
      geom.h = lbm_pkg::row_t'(height_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Front: raster position, flush gating, neighbor masks per pixel.
  // ---------------------------------------------------------------------------
  lbm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .restart         (cfg_wr),
    .geom            (geom),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_region_label (in_region_label),
    .in_flush        (in_flush),
    .qstat           (qstat),
    .push            (push),
    .push_item       (push_item)
  );

  // Decoupling queue between classifier and line-store datapath.
  lbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .qstat      (qstat)
  );

  // ---------------------------------------------------------------------------
  // Back: line stores, 3x3 window, boundary compare, colour delay, result buffer.
  // ---------------------------------------------------------------------------
  lbm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_on_boundary (out_on_boundary),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_frame_end   (out_frame_end),
    .bstat           (bstat)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // boundary pixels always come out pure red
  a_bnd_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_boundary |->
      out_blue == '0 && out_green == '0 && out_red == lbm_pkg::BoundaryRed)
    else $error("boundary pixel not painted red");

  // results in flight never exceed the result buffer
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(bstat.ocnt) + int'(bstat.r_valid)) <= lbm_pkg::ODepth)
    else $error("result buffer overcommitted");

  // a real pixel transfer always lands in the queue
  a_pix_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_flush |=> qstat.cnt != '0)
    else $error("accepted pixel missing from queue");

endmodule
